>>> rtl/rcf_pkg.sv
// ----------------------------------------------------------------------------
// rcf_pkg
// Shared types, constants and helpers for the 3x3 RGB convolution filter.
// ----------------------------------------------------------------------------
package rcf_pkg;

	localparam int unsigned MAX_WIDTH_DEF  = 1024;
	localparam int unsigned COEF_FRAC_BITS = 12;
	localparam int unsigned MAX_HEIGHT     = 4096;

	localparam int unsigned PIX_W  = 8;
	localparam int unsigned TAP_W  = 16;
	localparam int unsigned PROD_W = 25;
	localparam int unsigned RSUM_W = 27;
	localparam int unsigned SUM_W  = 28;
	localparam int unsigned ROW_W  = 48;
	localparam int unsigned WREG_W = 11;
	localparam int unsigned HREG_W = 13;
	localparam int unsigned INROW_W  = 13;
	localparam int unsigned OUTROW_W = 12;

	localparam int unsigned CFG_ADDR_W = 6;
	localparam int unsigned CFG_DATA_W = 64;

	localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

	localparam logic [WREG_W-1:0] WIDTH_RST  = 11'd1024;
	localparam logic [HREG_W-1:0] HEIGHT_RST = 13'd1;
	localparam logic [ROW_W-1:0]  KTOP_RST   = 48'd0;
	localparam logic [ROW_W-1:0]  KMID_RST   = 48'd4096;
	localparam logic [ROW_W-1:0]  KBOT_RST   = 48'd0;

	typedef enum logic [2:0] {
		REG_IMAGE_WIDTH   = 3'd0,
		REG_IMAGE_HEIGHT  = 3'd1,
		REG_KERNEL_TOP    = 3'd2,
		REG_KERNEL_MIDDLE = 3'd3,
		REG_KERNEL_BOTTOM = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic has_left;
		logic has_right;
		logic has_top;
		logic has_bottom;
	} nbr_t;

	typedef struct packed {
		logic valid;
		logic fend;
	} ctl_t;

	function automatic logic [PIX_W-1:0] clamp_pix(input logic signed [SUM_W-1:0] s);
		logic [SUM_W-1-COEF_FRAC_BITS:0] q;
		logic [PIX_W-1:0] res;
		q = s[SUM_W-1:COEF_FRAC_BITS];
		if (s < 0) begin
			res = '0;
		end else if (q > (SUM_W-COEF_FRAC_BITS)'(PIX_MAX)) begin
			res = PIX_MAX;
		end else begin
			res = q[PIX_W-1:0];
		end
		return res;
	endfunction

endpackage

>>> rtl/rcf_if.sv
// ----------------------------------------------------------------------------
// rcf_if
// Pixel stream channels: input pixels with flush marker, filtered output.
// ----------------------------------------------------------------------------
interface rcf_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] red_in;
	logic [7:0] green_in;
	logic [7:0] blue_in;
	logic       flush_item;

	modport source(output valid, output red_in, output green_in, output blue_in,
		output flush_item, input ready);
	modport sink(input valid, input red_in, input green_in, input blue_in,
		input flush_item, output ready);
endinterface

interface rcf_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] red_out;
	logic [7:0] green_out;
	logic [7:0] blue_out;
	logic       frame_end;

	modport source(output valid, output red_out, output green_out, output blue_out,
		output frame_end, input ready);
	modport sink(input valid, input red_out, input green_out, input blue_out,
		input frame_end, output ready);
endinterface

>>> rtl/rcf_mac.sv
// ----------------------------------------------------------------------------
// rcf_mac
// Kernel multiply-accumulate: edge-masked taps times window pixels, row sums,
// then total and clamp per channel.
// ----------------------------------------------------------------------------
module rcf_mac (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic [23:0]                  win [9],
	input  logic [rcf_pkg::ROW_W-1:0]    krow [3],
	input  rcf_pkg::nbr_t                nbr_s2,
	input  rcf_pkg::ctl_t                ctl_s2,
	output rcf_pkg::ctl_t                ctl_s4,
	output logic [rcf_pkg::PIX_W-1:0]    chan [3]
);

	logic signed [rcf_pkg::PROD_W-1:0] prod      [3][9];
	logic signed [rcf_pkg::PROD_W-1:0] prod_s3   [3][9];
	logic signed [rcf_pkg::RSUM_W-1:0] rsum_s4   [3][3];
	logic signed [rcf_pkg::SUM_W-1:0]  total     [3];
	rcf_pkg::ctl_t                     ctl_s3;

	// masked neighbors contribute zero on both operands
	always_comb begin
		logic                              use_tap;
		logic signed [rcf_pkg::TAP_W-1:0]  tap;
		logic signed [rcf_pkg::PIX_W:0]    px;
		for (int r = 0; r < 3; r++) begin
			for (int k = 0; k < 3; k++) begin
				use_tap = !((r == 0) && !nbr_s2.has_top) && !((r == 2) && !nbr_s2.has_bottom)
					&& !((k == 0) && !nbr_s2.has_left) && !((k == 2) && !nbr_s2.has_right);
				tap = use_tap ? krow[r][k*rcf_pkg::TAP_W +: rcf_pkg::TAP_W] : '0;
				for (int ch = 0; ch < 3; ch++) begin
					px = use_tap ? {1'b0, win[r*3+k][ch*rcf_pkg::PIX_W +: rcf_pkg::PIX_W]}
						: '0;
					prod[ch][r*3+k] = tap * px;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s3 <= prod;
			for (int ch = 0; ch < 3; ch++) begin
				for (int r = 0; r < 3; r++) begin
					rsum_s4[ch][r] <= rcf_pkg::RSUM_W'(prod_s3[ch][r*3])
						+ rcf_pkg::RSUM_W'(prod_s3[ch][r*3+1])
						+ rcf_pkg::RSUM_W'(prod_s3[ch][r*3+2]);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
			ctl_s4 <= '0;
		end else if (en) begin
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
		end
	end

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			total[ch] = rcf_pkg::SUM_W'(rsum_s4[ch][0]) + rcf_pkg::SUM_W'(rsum_s4[ch][1])
				+ rcf_pkg::SUM_W'(rsum_s4[ch][2]);
			chan[ch] = rcf_pkg::clamp_pix(total[ch]);
		end
	end

endmodule

>>> rtl/rgb_conv3x3_filter.sv
// ----------------------------------------------------------------------------
// rgb_conv3x3_filter
// 3x3 zero-padded RGB convolution over a raster pixel stream, line buffer in
// one synchronous RAM, one kernel shared by all three channels.
// ----------------------------------------------------------------------------
//  channel   dir  handshake            payload
//  pix_in    in   valid/ready          red_in, green_in, blue_in, flush_item
//  pix_out   out  valid/ready          red_out, green_out, blue_out, frame_end
//  apb       in   psel/penable/pready  paddr[5:3] index, 64-bit pwdata/prdata
//
//  One transaction per clock sustained while pix_out does not stall; a result
//  moves through stage 1, window, product, row-sum and output registers.
//  The line buffer RAM (one read, one write port) is read at accept and
//  written back from stage 1; a same-address overlap is forwarded.
//  Reset clears counters, window and config; the RAM needs no clearing pass.
//  A stall on pix_out freezes the whole pipeline and drops pix_in.ready.
// ----------------------------------------------------------------------------
module rgb_conv3x3_filter #(
	parameter int unsigned MAX_WIDTH = rcf_pkg::MAX_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	rcf_in_if.sink                          pix_in,
	rcf_out_if.source                       pix_out,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [rcf_pkg::CFG_ADDR_W-1:0]  paddr,
	input  logic [rcf_pkg::CFG_DATA_W-1:0]  pwdata,
	output logic [rcf_pkg::CFG_DATA_W-1:0]  prdata,
	output logic                            pready
);

	localparam int unsigned CW = $clog2(MAX_WIDTH);
	localparam int unsigned WW = (CW + 1 > rcf_pkg::WREG_W) ? CW + 1 : rcf_pkg::WREG_W;

	// configuration
	logic [rcf_pkg::WREG_W-1:0]   width_q;
	logic [rcf_pkg::HREG_W-1:0]   height_q;
	logic [rcf_pkg::ROW_W-1:0]    krow_q [3];
	logic [WW-1:0]                w_last;
	logic [rcf_pkg::OUTROW_W-1:0] h_last;
	logic [WW-1:0]                w_eff;
	logic [rcf_pkg::HREG_W-1:0]   h_eff;
	logic                         cfg_wr;
	rcf_pkg::reg_idx_t            cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = rcf_pkg::reg_idx_t'(paddr[5:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= rcf_pkg::WIDTH_RST;
			height_q  <= rcf_pkg::HEIGHT_RST;
			krow_q[0] <= rcf_pkg::KTOP_RST;
			krow_q[1] <= rcf_pkg::KMID_RST;
			krow_q[2] <= rcf_pkg::KBOT_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				rcf_pkg::REG_IMAGE_WIDTH:   width_q   <= pwdata[rcf_pkg::WREG_W-1:0];
				rcf_pkg::REG_IMAGE_HEIGHT:  height_q  <= pwdata[rcf_pkg::HREG_W-1:0];
				rcf_pkg::REG_KERNEL_TOP:    krow_q[0] <= pwdata[rcf_pkg::ROW_W-1:0];
				rcf_pkg::REG_KERNEL_MIDDLE: krow_q[1] <= pwdata[rcf_pkg::ROW_W-1:0];
				rcf_pkg::REG_KERNEL_BOTTOM: krow_q[2] <= pwdata[rcf_pkg::ROW_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			rcf_pkg::REG_IMAGE_WIDTH:   prdata = rcf_pkg::CFG_DATA_W'(width_q);
			rcf_pkg::REG_IMAGE_HEIGHT:  prdata = rcf_pkg::CFG_DATA_W'(height_q);
			rcf_pkg::REG_KERNEL_TOP:    prdata = rcf_pkg::CFG_DATA_W'(krow_q[0]);
			rcf_pkg::REG_KERNEL_MIDDLE: prdata = rcf_pkg::CFG_DATA_W'(krow_q[1]);
			rcf_pkg::REG_KERNEL_BOTTOM: prdata = rcf_pkg::CFG_DATA_W'(krow_q[2]);
			default:                    prdata = '0;
		endcase
	end

	always_comb begin
		if (width_q == '0) begin
			w_eff = WW'(1);
		end else if (WW'(width_q) > WW'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(width_q);
		end
		if (height_q == '0) begin
			h_eff = rcf_pkg::HREG_W'(1);
		end else if (height_q > rcf_pkg::HREG_W'(rcf_pkg::MAX_HEIGHT)) begin
			h_eff = rcf_pkg::HREG_W'(rcf_pkg::MAX_HEIGHT);
		end else begin
			h_eff = height_q;
		end
		w_last = w_eff - WW'(1);
		h_last = rcf_pkg::OUTROW_W'(h_eff - rcf_pkg::HREG_W'(1));
	end

	// stream position counters
	logic                          adv;
	logic                          acc;
	logic [CW-1:0]                 in_col_q;
	logic [rcf_pkg::INROW_W-1:0]   in_row_q;
	logic [CW-1:0]                 out_col_q;
	logic [rcf_pkg::OUTROW_W-1:0]  out_row_q;
	logic                          emit;
	logic                          fend;
	logic                          in_col_end;
	logic                          out_col_end;
	rcf_pkg::nbr_t                 nbr;
	logic [23:0]                   pix;
	logic                          out_valid_q;

	assign adv          = !out_valid_q || pix_out.ready;
	assign acc          = pix_in.valid && adv;
	assign pix_in.ready = adv;

	always_comb begin
		emit = (in_row_q >= rcf_pkg::INROW_W'(2))
			|| ((in_row_q == rcf_pkg::INROW_W'(1)) && (in_col_q != '0));
		in_col_end      = WW'(in_col_q) >= w_last;
		out_col_end     = WW'(out_col_q) >= w_last;
		nbr.has_left    = out_col_q != '0;
		nbr.has_right   = WW'(out_col_q) < w_last;
		nbr.has_top     = out_row_q != '0;
		nbr.has_bottom  = out_row_q < h_last;
		fend            = (out_row_q >= h_last) && out_col_end;
		pix             = pix_in.flush_item ? 24'd0
			: {pix_in.blue_in, pix_in.green_in, pix_in.red_in};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (acc) begin
			if (emit && fend) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end else begin
				if (in_col_end) begin
					in_col_q <= '0;
					if (in_row_q != '1) begin
						in_row_q <= in_row_q + rcf_pkg::INROW_W'(1);
					end
				end else begin
					in_col_q <= in_col_q + CW'(1);
				end
				if (emit) begin
					if (out_col_end) begin
						out_col_q <= '0;
						if (out_row_q != '1) begin
							out_row_q <= out_row_q + rcf_pkg::OUTROW_W'(1);
						end
					end else begin
						out_col_q <= out_col_q + CW'(1);
					end
				end
			end
		end
	end

	// stage 1: line buffer read data, forwarding, write-back
	logic [47:0]   lmem [MAX_WIDTH];
	logic [47:0]   rdata_s1;
	logic [47:0]   fwd_data_s1;
	logic          fwd_s1;
	logic          valid_s1;
	logic          emit_s1;
	logic          fend_s1;
	rcf_pkg::nbr_t nbr_s1;
	logic [23:0]   pix_s1;
	logic [CW-1:0] col_s1;
	logic [47:0]   line_s1;
	logic          wr_en;

	assign line_s1 = fwd_s1 ? fwd_data_s1 : rdata_s1;
	assign wr_en   = valid_s1 && adv;

	always_ff @(posedge clk) begin
		if (acc) begin
			rdata_s1 <= lmem[in_col_q];
		end
		if (wr_en) begin
			lmem[col_s1] <= {line_s1[23:0], pix_s1};
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			fwd_data_s1 <= {line_s1[23:0], pix_s1};
			pix_s1      <= pix;
			col_s1      <= in_col_q;
			emit_s1     <= emit;
			fend_s1     <= fend;
			nbr_s1      <= nbr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
		end else if (adv) begin
			valid_s1 <= acc;
			if (acc) begin
				fwd_s1 <= wr_en && (col_s1 == in_col_q);
			end
		end
	end

	// stage 2: 3x3 window
	logic [23:0]   win_q [9];
	rcf_pkg::ctl_t ctl_s2;
	rcf_pkg::nbr_t nbr_s2;
	rcf_pkg::ctl_t ctl_s4;
	logic [7:0]    chan [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) begin
				win_q[i] <= '0;
			end
			ctl_s2 <= '0;
			nbr_s2 <= '0;
		end else if (adv) begin
			ctl_s2.valid <= valid_s1 && emit_s1;
			ctl_s2.fend  <= fend_s1;
			nbr_s2       <= nbr_s1;
			if (valid_s1) begin
				for (int r = 0; r < 3; r++) begin
					win_q[r*3]   <= win_q[r*3+1];
					win_q[r*3+1] <= win_q[r*3+2];
				end
				win_q[2] <= line_s1[47:24];
				win_q[5] <= line_s1[23:0];
				win_q[8] <= pix_s1;
			end
		end
	end

	rcf_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.win    (win_q),
		.krow   (krow_q),
		.nbr_s2 (nbr_s2),
		.ctl_s2 (ctl_s2),
		.ctl_s4 (ctl_s4),
		.chan   (chan)
	);

	// output register
	logic [7:0] red_q;
	logic [7:0] green_q;
	logic [7:0] blue_q;
	logic       fend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= ctl_s4.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			red_q   <= chan[0];
			green_q <= chan[1];
			blue_q  <= chan[2];
			fend_q  <= ctl_s4.fend;
		end
	end

	assign pix_out.valid     = out_valid_q;
	assign pix_out.red_out   = red_q;
	assign pix_out.green_out = green_q;
	assign pix_out.blue_out  = blue_q;
	assign pix_out.frame_end = fend_q;

endmodule
